### rtl/vgco_pkg.sv
package vgco_pkg;

   // Field widths fixed by the pixel format and the register map.
   localparam int ROW_W   = 10;
   localparam int PIX_W   = 32;
   localparam int CHAN_W  = 8;
   localparam int NCHAN   = 3;
   localparam int COLOR_W = 9;
   localparam int ROWS_W  = 11;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Quotient magnitude stays below 512 because row < rows and |bottom - top| <= 511.
   localparam int QUOT_W = 9;
   localparam int PROD_W = COLOR_W + ROW_W;

   localparam int DEFAULT_MAX_ROWS = 1024;

   // Channel slots inside a pixel word.
   localparam int CH_BLUE  = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_RED   = 2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_TOP_RED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_GREEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOP_BLUE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_RED   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_GREEN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BOTTOM_BLUE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_BAND_ROWS    = 3'd6;

   localparam logic signed [COLOR_W-1:0] TOP_RESET    = 9'sd0;
   localparam logic signed [COLOR_W-1:0] BOTTOM_RESET = 9'sd255;
   localparam logic [ROWS_W-1:0]         ROWS_RESET   = 11'd1024;

   // One word in flight through the divider.
   typedef struct packed {
      logic                               in_band;
      logic [PIX_W-1:0]                   pixel;
      logic [NCHAN-1:0]                   neg;
      logic [NCHAN-1:0][PROD_W-1:0]       rem;
      logic [NCHAN-1:0][QUOT_W-1:0]       quo;
   } vgco_div_type;

   // One word after the offsets are formed and limited.
   typedef struct packed {
      logic                                    in_band;
      logic [PIX_W-1:0]                        pixel;
      logic [NCHAN-1:0][COLOR_W-1:0]           off;
   } vgco_off_type;

endpackage

### rtl/vertical_gradient_color_offset_top.sv
// Pipeline: an accepted word passes one multiply stage, one divider stage per quotient bit,
//   one offset stage and the output register, then shows on rsp_valid.
// Throughput: one word per cycle while rsp_stall is low; the per-bit restoring divider stages set the depth.
// Reset: clears every stage valid bit and loads the register defaults
//   (top colors 0, bottom colors 255, band height 1024).
module vertical_gradient_color_offset_top #(
   parameter int MAX_ROWS = vgco_pkg::DEFAULT_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [vgco_pkg::ROW_W-1:0]        req_row_in_band,
   input  logic [vgco_pkg::PIX_W-1:0]        req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [vgco_pkg::PIX_W-1:0]        rsp_pixel_out,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [vgco_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [vgco_pkg::CSR_DATA_W-1:0]   csr_data
);
   import vgco_pkg::*;

   // Width of the effective band height, which never exceeds MAX_ROWS.
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int BIG_W = (RW > ROWS_W) ? RW : ROWS_W;
   // Compare width for the divider: holds rows << (QUOT_W-1) and any remainder.
   localparam int CMP_W = (PROD_W > RW + QUOT_W) ? PROD_W : RW + QUOT_W;

   // ---------------------------------------------------------------------------------------
   // Configuration registers, indexed by channel slot.
   // ---------------------------------------------------------------------------------------
   logic signed [COLOR_W-1:0] top_ff [NCHAN];
   logic signed [COLOR_W-1:0] bot_ff [NCHAN];
   logic [ROWS_W-1:0]         band_rows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCHAN; c++) begin
            top_ff[c] <= TOP_RESET;
            bot_ff[c] <= BOTTOM_RESET;
         end
         band_rows_ff <= ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TOP_RED:      top_ff[CH_RED]   <= csr_data[COLOR_W-1:0];
            REG_TOP_GREEN:    top_ff[CH_GREEN] <= csr_data[COLOR_W-1:0];
            REG_TOP_BLUE:     top_ff[CH_BLUE]  <= csr_data[COLOR_W-1:0];
            REG_BOTTOM_RED:   bot_ff[CH_RED]   <= csr_data[COLOR_W-1:0];
            REG_BOTTOM_GREEN: bot_ff[CH_GREEN] <= csr_data[COLOR_W-1:0];
            REG_BOTTOM_BLUE:  bot_ff[CH_BLUE]  <= csr_data[COLOR_W-1:0];
            REG_BAND_ROWS:    band_rows_ff     <= csr_data[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Band height limited to MAX_ROWS. The user must change registers only while the pipe is empty;
   // the block does not enforce this (csr_ready is always high), and every stage reads them directly.
   logic [RW-1:0] rows_eff;

   always_comb begin
      if (BIG_W'(band_rows_ff) > BIG_W'(MAX_ROWS)) begin
         rows_eff = RW'(MAX_ROWS);
      end else begin
         rows_eff = RW'(band_rows_ff);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stage registers and the ready chain. A stage loads when it is empty or when the stage
   // after it loads too, so bubbles collapse and a stalled output never drops a word.
   // ---------------------------------------------------------------------------------------
   vgco_div_type                div_ff     [QUOT_W+1];
   logic [QUOT_W:0]             div_vld_ff;
   vgco_div_type                entry_in;
   vgco_div_type                div_in     [1:QUOT_W];
   logic [QUOT_W:0]             div_rdy;
   vgco_off_type                off_ff;
   vgco_off_type                off_in;
   logic                        off_vld_ff;
   logic                        off_rdy;
   logic [PIX_W-1:0]            rsp_pixel_ff;
   logic [PIX_W-1:0]            rsp_pixel_in;
   logic                        rsp_inside_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_rdy;

   always_comb begin
      rsp_rdy = !rsp_valid_ff || !rsp_stall;
      off_rdy = !off_vld_ff || rsp_rdy;
      div_rdy[QUOT_W] = !div_vld_ff[QUOT_W] || off_rdy;
      for (int j = QUOT_W - 1; j >= 0; j--) begin
         div_rdy[j] = !div_vld_ff[j] || div_rdy[j+1];
      end
   end

   assign req_stall = !div_rdy[0];

   // ---------------------------------------------------------------------------------------
   // Entry stage: band test and |bottom - top| * row per channel.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      logic signed [COLOR_W:0] diff;
      logic [COLOR_W:0]        mag;
      entry_in.in_band = (rows_eff != '0) &&
                         (BIG_W'(req_row_in_band) < BIG_W'(rows_eff));
      entry_in.pixel   = req_pixel_in;
      entry_in.quo     = '0;
      diff = '0;
      mag  = '0;
      for (int c = 0; c < NCHAN; c++) begin
         diff = {bot_ff[c][COLOR_W-1], bot_ff[c]} - {top_ff[c][COLOR_W-1], top_ff[c]};
         mag  = diff[COLOR_W] ? (COLOR_W+1)'(-diff) : diff;
         entry_in.neg[c] = diff[COLOR_W];
         entry_in.rem[c] = PROD_W'(mag[COLOR_W-1:0]) * PROD_W'(req_row_in_band);
      end
   end

   // ---------------------------------------------------------------------------------------
   // Restoring divider: stage j settles quotient bit QUOT_W-1-j of every channel.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      logic [CMP_W-1:0] dvs;
      logic [CMP_W-1:0] remx;
      dvs  = '0;
      remx = '0;
      for (int j = 0; j < QUOT_W; j++) begin
         div_in[j+1] = div_ff[j];
         dvs = CMP_W'(rows_eff) << (QUOT_W - 1 - j);
         for (int c = 0; c < NCHAN; c++) begin
            remx = CMP_W'(div_ff[j].rem[c]);
            if (remx >= dvs) begin
               div_in[j+1].rem[c] = PROD_W'(remx - dvs);
               div_in[j+1].quo[c][QUOT_W-1-j] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
      end else begin
         if (div_rdy[0]) begin
            div_vld_ff[0] <= req_valid;
         end
         for (int j = 0; j < QUOT_W; j++) begin
            if (div_rdy[j+1]) begin
               div_vld_ff[j+1] <= div_vld_ff[j];
            end
         end
      end
   end

   // Payload carries no reset; it follows the valid bits.
   always_ff @(posedge clock) begin
      if (div_rdy[0]) begin
         div_ff[0] <= entry_in;
      end
      for (int j = 0; j < QUOT_W; j++) begin
         if (div_rdy[j+1]) begin
            div_ff[j+1] <= div_in[j+1];
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Offset stage: apply sign (truncation toward zero), add top color, limit to +-255.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      logic signed [COLOR_W:0]   sq;
      logic signed [COLOR_W+1:0] sum;
      off_in.in_band = div_ff[QUOT_W].in_band;
      off_in.pixel   = div_ff[QUOT_W].pixel;
      sq  = '0;
      sum = '0;
      for (int c = 0; c < NCHAN; c++) begin
         sq = {1'b0, div_ff[QUOT_W].quo[c]};
         if (div_ff[QUOT_W].neg[c]) begin
            sq = -sq;
         end
         sum = {{2{top_ff[c][COLOR_W-1]}}, top_ff[c]} + {sq[COLOR_W], sq};
         if (sum > 11'sd255) begin
            off_in.off[c] = 9'd255;
         end else if (sum < -11'sd255) begin
            off_in.off[c] = 9'h101;
         end else begin
            off_in.off[c] = sum[COLOR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_vld_ff <= 1'b0;
      end else if (off_rdy) begin
         off_vld_ff <= div_vld_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (off_rdy) begin
         off_ff <= off_in;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Output stage: add offset to each channel, clamp to 0..255, zero alpha inside the band,
   // pass the word through untouched outside it.
   // ---------------------------------------------------------------------------------------
   always_comb begin
      logic signed [COLOR_W+1:0] sum;
      logic [PIX_W-1:0]          shaded;
      sum    = '0;
      shaded = '0;
      for (int c = 0; c < NCHAN; c++) begin
         sum = {3'b000, off_ff.pixel[c*CHAN_W +: CHAN_W]} +
               {{2{off_ff.off[c][COLOR_W-1]}}, off_ff.off[c]};
         if (sum[COLOR_W+1]) begin
            shaded[c*CHAN_W +: CHAN_W] = '0;
         end else if (sum > 11'sd255) begin
            shaded[c*CHAN_W +: CHAN_W] = '1;
         end else begin
            shaded[c*CHAN_W +: CHAN_W] = sum[CHAN_W-1:0];
         end
      end
      rsp_pixel_in = off_ff.in_band ? shaded : off_ff.pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_rdy) begin
         rsp_valid_ff <= off_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_rdy) begin
         rsp_pixel_ff  <= rsp_pixel_in;
         rsp_inside_ff <= off_ff.in_band;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;

   // ---------------------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------------------
   // After the last quotient bit, an in-band word leaves a remainder below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (div_vld_ff[QUOT_W] && div_ff[QUOT_W].in_band) |->
         (CMP_W'(div_ff[QUOT_W].rem[0]) < CMP_W'(rows_eff)) &&
         (CMP_W'(div_ff[QUOT_W].rem[1]) < CMP_W'(rows_eff)) &&
         (CMP_W'(div_ff[QUOT_W].rem[2]) < CMP_W'(rows_eff)))
      else $error("divider remainder not below band height");

   // Limited offsets never reach -256.
   a_off_range: assert property (@(posedge clock) disable iff (reset)
      off_vld_ff |-> (off_ff.off[0] != 9'h100) && (off_ff.off[1] != 9'h100) &&
                     (off_ff.off[2] != 9'h100))
      else $error("offset outside -255..255");

   // An in-band word always leaves with alpha cleared.
   a_alpha_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff) |-> (rsp_pixel_ff[PIX_W-1 -: CHAN_W] == '0))
      else $error("alpha not cleared inside band");

   // A word at the divider tail that cannot move is still there next cycle.
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (div_vld_ff[QUOT_W] && !off_rdy) |=> div_vld_ff[QUOT_W])
      else $error("word lost at divider tail");

endmodule
